FILE: hw/rtl/t1bfp_pkg.sv
// ----------------------------------------------------------------------------
// T=1 block frame parser package
// Shared types and code constants for the T=1 block parser and its APDU
// chain tracker.
// ----------------------------------------------------------------------------
package t1bfp_pkg;

    // Parser phase codes
    localparam logic [2:0] PH_NAD = 3'd0;
    localparam logic [2:0] PH_PCB = 3'd1;
    localparam logic [2:0] PH_LEN = 3'd2;
    localparam logic [2:0] PH_INF = 3'd3;
    localparam logic [2:0] PH_EDC = 3'd4;

    // Byte role codes
    localparam logic [2:0] ROLE_NAD = 3'd0;
    localparam logic [2:0] ROLE_PCB = 3'd1;
    localparam logic [2:0] ROLE_LEN = 3'd2;
    localparam logic [2:0] ROLE_INF = 3'd3;
    localparam logic [2:0] ROLE_LRC = 3'd4;
    localparam logic [2:0] ROLE_CRC = 3'd5;

    // Block kind codes
    localparam logic [1:0] KIND_I = 2'd0;
    localparam logic [1:0] KIND_R = 2'd1;
    localparam logic [1:0] KIND_S = 2'd2;

    // PCB bit masks
    localparam logic [7:0] PCB_R_OR_S = 8'h80;
    localparam logic [7:0] PCB_MORE   = 8'h20;
    localparam logic [7:0] PCB_KIND   = 8'hC0;

    // Configuration register index
    localparam logic REG_EDC_IS_CRC = 1'b0;

    // Events from the block parser to the chain tracker
    typedef struct packed {
        logic        len_ev;       // LEN byte of an I-block
        logic        info_ev;      // information byte of an I-block
        logic        end_ev;       // last EDC byte of an I-block with M clear
        logic [7:0]  data;         // current character value
        logic [47:0] frame_start;  // start sample of the current block
    } t_chain_ctl;

    // Chain state after the current transaction
    typedef struct packed {
        logic        done;
        logic [15:0] total_len;
        logic [3:0]  first_count;
        logic [63:0] first_bytes;
        logic [47:0] start_time;
    } t_chain_view;

    // One result item
    typedef struct packed {
        logic [2:0]  byte_role;
        logic [7:0]  role_index;
        logic [1:0]  block_kind;
        logic [7:0]  block_pcb;
        logic        block_done;
        logic [47:0] block_start_time;
        logic [47:0] block_end_time;
        t_chain_view chain;
    } t_result;

    // Block kind from a PCB value
    function automatic logic [1:0] kind_of(input logic [7:0] pcb);
        logic [1:0] k;
        if ((pcb & PCB_R_OR_S) == 8'h00) begin
            k = KIND_I;
        end else if ((pcb & PCB_KIND) == PCB_R_OR_S) begin
            k = KIND_R;
        end else begin
            k = KIND_S;
        end
        return k;
    endfunction

endpackage

FILE: hw/rtl/t1bfp_chain.sv
// ----------------------------------------------------------------------------
// T=1 APDU chain tracker
// Follows chained I-blocks, keeps the saturating total length, the start
// sample of the chain and the leading information bytes.
// ----------------------------------------------------------------------------
module t1bfp_chain #(
    parameter int CAPTURE_BYTES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  t1bfp_pkg::t_chain_ctl i_ctl,
    output t1bfp_pkg::t_chain_view o_view
);
    import t1bfp_pkg::*;

    localparam int CW = $clog2(CAPTURE_BYTES + 1);

    logic                           r_active;
    logic [15:0]                    r_len;
    logic [CW-1:0]                  r_count;
    logic [CAPTURE_BYTES-1:0][7:0]  r_bytes;
    logic [47:0]                    r_start;

    logic                           n_active;
    logic [15:0]                    n_len;
    logic [CW-1:0]                  n_count;
    logic [CAPTURE_BYTES-1:0][7:0]  n_bytes;
    logic [47:0]                    n_start;
    logic [15:0]                    base_len;
    logic [16:0]                    sum_len;
    logic                           cap_en;
    logic                           done;

    // Next chain state for the character in flight
    always_comb begin
        n_active = r_active;
        n_len    = r_len;
        n_count  = r_count;
        n_bytes  = r_bytes;
        n_start  = r_start;
        done     = 1'b0;
        base_len = r_len;
        sum_len  = '0;
        cap_en   = 1'b0;

        if (i_ctl.len_ev) begin
            // A chain opens on the first I-block LEN seen while idle.
            if (!r_active) begin
                n_active = 1'b1;
                n_start  = i_ctl.frame_start;
                base_len = '0;
                n_count  = '0;
                n_bytes  = '0;
            end
            sum_len = {1'b0, base_len} + {9'd0, i_ctl.data};
            n_len   = sum_len[16] ? 16'hFFFF : sum_len[15:0];
        end

        if (i_ctl.info_ev && r_active && (r_count < CW'(CAPTURE_BYTES))) begin
            cap_en  = 1'b1;
            n_count = r_count + CW'(1);
        end
        for (int l = 0; l < CAPTURE_BYTES; l++) begin
            if (cap_en && (r_count == CW'(l))) begin
                n_bytes[l] = i_ctl.data;
            end
        end

        if (i_ctl.end_ev && r_active) begin
            done     = 1'b1;
            n_active = 1'b0;
        end
    end

    // Chain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_len    <= '0;
            r_count  <= '0;
            r_bytes  <= '0;
            r_start  <= '0;
        end else if (i_step) begin
            r_active <= n_active;
            r_len    <= n_len;
            r_count  <= n_count;
            r_bytes  <= n_bytes;
            r_start  <= n_start;
        end
    end

    // The view shows the state after this transaction.
    assign o_view.done        = done;
    assign o_view.total_len   = n_len;
    assign o_view.first_count = 4'(n_count);
    assign o_view.first_bytes = 64'(n_bytes);
    assign o_view.start_time  = n_start;

endmodule

FILE: hw/rtl/t1_block_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// T=1 block frame parser
// Classifies each received smart-card character within the T=1 block layout
// and tracks chained I-blocks as one APDU.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while the skid stage is empty
// and returns one result for each from a result register. All per-character
// work is a single pass of short logic on the parser phase and the chain
// registers, so the phase update is the only loop. A second result stage
// catches a result while the output is stalled, so input transactions keep
// flowing until both stages are full.
// The EDC length (one LRC or two CRC bytes) is sampled from the
// configuration register when each PCB byte arrives.
module t1_block_frame_parser_unit #(
    parameter int CAPTURE_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Character input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_value,
    input  logic [47:0] i_byte_start_time,
    input  logic [47:0] i_byte_end_time,

    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_byte_role,
    output logic [7:0]  o_role_index,
    output logic [1:0]  o_block_kind,
    output logic [7:0]  o_block_pcb,
    output logic        o_block_done,
    output logic [47:0] o_block_start_time,
    output logic [47:0] o_block_end_time,
    output logic        o_apdu_done,
    output logic [15:0] o_apdu_total_len,
    output logic [3:0]  o_apdu_first_count,
    output logic [63:0] o_apdu_first_bytes,
    output logic [47:0] o_apdu_start_time,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import t1bfp_pkg::*;

    logic        r_edc_crc;
    logic        r_epi_crc;
    logic [2:0]  r_phase;
    logic [7:0]  r_ctrl;
    logic [7:0]  r_info_len;
    logic [7:0]  r_info_count;
    logic [1:0]  r_check_count;
    logic [47:0] r_frame_start;

    logic        n_epi_crc;
    logic [2:0]  n_phase;
    logic [7:0]  n_ctrl;
    logic [7:0]  n_info_len;
    logic [7:0]  n_info_count;
    logic [1:0]  n_check_count;
    logic [47:0] n_frame_start;

    logic        in_fire;
    logic        out_fire;
    logic        cfg_wr;
    logic        iblock;
    logic [2:0]  role;
    logic [7:0]  idx;
    logic        bdone;
    logic [1:0]  epi_len;

    t_chain_ctl  chain_ctl;
    t_chain_view chain_view;
    t_result     res;

    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    assign o_in_ready = !r_skid_valid;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;

    // Configuration register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_EDC_IS_CRC) ? {31'd0, r_edc_crc} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edc_crc <= 1'b0;
        end else if (cfg_wr && (paddr[2] == REG_EDC_IS_CRC)) begin
            r_edc_crc <= pwdata[0];
        end
    end

    // Block layout walk for the character in flight
    always_comb begin
        n_phase       = r_phase;
        n_ctrl        = r_ctrl;
        n_epi_crc     = r_epi_crc;
        n_info_len    = r_info_len;
        n_info_count  = r_info_count;
        n_check_count = r_check_count;
        n_frame_start = r_frame_start;
        role          = ROLE_NAD;
        idx           = 8'd0;
        bdone         = 1'b0;
        iblock        = (r_ctrl & PCB_R_OR_S) == 8'h00;
        epi_len       = r_epi_crc ? 2'd2 : 2'd1;
        chain_ctl.len_ev      = 1'b0;
        chain_ctl.info_ev     = 1'b0;
        chain_ctl.end_ev      = 1'b0;
        chain_ctl.data        = i_byte_value;
        chain_ctl.frame_start = r_frame_start;

        unique case (r_phase)
            PH_PCB: begin
                role      = ROLE_PCB;
                n_ctrl    = i_byte_value;
                n_epi_crc = r_edc_crc;
                n_phase   = PH_LEN;
            end
            PH_LEN: begin
                role             = ROLE_LEN;
                n_info_len       = i_byte_value;
                n_info_count     = 8'd0;
                n_check_count    = 2'd0;
                chain_ctl.len_ev = iblock;
                n_phase          = (i_byte_value == 8'd0) ? PH_EDC : PH_INF;
            end
            PH_INF: begin
                role              = ROLE_INF;
                idx               = r_info_count;
                chain_ctl.info_ev = iblock;
                n_info_count      = r_info_count + 8'd1;
                if (n_info_count >= r_info_len) begin
                    n_check_count = 2'd0;
                    n_phase       = PH_EDC;
                end
            end
            PH_EDC: begin
                role          = r_epi_crc ? ROLE_CRC : ROLE_LRC;
                idx           = r_epi_crc ? {6'd0, r_check_count} : 8'd0;
                n_check_count = r_check_count + 2'd1;
                if (n_check_count >= epi_len) begin
                    bdone            = 1'b1;
                    chain_ctl.end_ev = iblock && ((r_ctrl & PCB_MORE) == 8'h00);
                    n_phase          = PH_NAD;
                end
            end
            default: begin
                // NAD byte, which also serves any unused phase code
                role          = ROLE_NAD;
                n_frame_start = i_byte_start_time;
                n_phase       = PH_PCB;
            end
        endcase
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_NAD;
            r_ctrl        <= '0;
            r_epi_crc     <= 1'b0;
            r_info_len    <= '0;
            r_info_count  <= '0;
            r_check_count <= '0;
            r_frame_start <= '0;
        end else if (in_fire) begin
            r_phase       <= n_phase;
            r_ctrl        <= n_ctrl;
            r_epi_crc     <= n_epi_crc;
            r_info_len    <= n_info_len;
            r_info_count  <= n_info_count;
            r_check_count <= n_check_count;
            r_frame_start <= n_frame_start;
        end
    end

    // APDU chain tracking
    t1bfp_chain #(
        .CAPTURE_BYTES(CAPTURE_BYTES)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_fire),
        .i_ctl   (chain_ctl),
        .o_view  (chain_view)
    );

    // Assemble the result item
    always_comb begin
        res.byte_role        = role;
        res.role_index       = idx;
        res.block_kind       = kind_of(n_ctrl);
        res.block_pcb        = n_ctrl;
        res.block_done       = bdone;
        res.block_start_time = n_frame_start;
        res.block_end_time   = i_byte_end_time;
        res.chain            = chain_view;
    end

    // Result register with a skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (in_fire) begin
            r_skid <= res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_byte_role        = r_out.byte_role;
    assign o_role_index       = r_out.role_index;
    assign o_block_kind       = r_out.block_kind;
    assign o_block_pcb        = r_out.block_pcb;
    assign o_block_done       = r_out.block_done;
    assign o_block_start_time = r_out.block_start_time;
    assign o_block_end_time   = r_out.block_end_time;
    assign o_apdu_done        = r_out.chain.done;
    assign o_apdu_total_len   = r_out.chain.total_len;
    assign o_apdu_first_count = r_out.chain.first_count;
    assign o_apdu_first_bytes = r_out.chain.first_bytes;
    assign o_apdu_start_time  = r_out.chain.start_time;

`ifndef SYNTH
    // The skid stage only fills behind a held result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a transaction while the result register is empty");

    // An APDU can only complete on the last byte of a block.
    a_apdu_on_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.chain.done) |-> r_out.block_done)
        else $error("APDU completed without a block end");

    // A block ends only on an EDC byte.
    a_block_end_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.block_done) |->
            (r_out.byte_role == ROLE_LRC || r_out.byte_role == ROLE_CRC))
        else $error("block end reported on a non-EDC byte");

    // A NAD byte is always followed by a PCB byte.
    a_nad_then_pcb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_phase == PH_NAD) |=> (r_phase == PH_PCB))
        else $error("parser did not move to the PCB after a NAD");
`endif

endmodule
